// ===== hdl/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg
// Shared widths, register indexes, reset values and sequencer states of the
// accelerometer step detector.
// ----------------------------------------------------------------------------
`default_nettype none

package asd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 32;

  localparam int MAG_W       = 16;
  localparam int TIME_W      = 32;
  localparam int OUT_COUNT_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

  localparam logic [CFG_DATA_W-1:0] ALPHA_RST     = 16'd61604;
  localparam logic [CFG_DATA_W-1:0] FILT_UP_RST   = 16'd717;
  localparam logic [CFG_DATA_W-1:0] FILT_LOW_RST  = 16'd307;
  localparam logic [CFG_DATA_W-1:0] MIN_STEP_RST  = 16'd300;
  localparam logic [CFG_DATA_W-1:0] RAW_UP_RST    = 16'd3072;
  localparam logic [CFG_DATA_W-1:0] RAW_LOW_RST   = 16'd2688;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA    = 3'd0,
    REG_FILT_UP  = 3'd1,
    REG_FILT_LOW = 3'd2,
    REG_MIN_STEP = 3'd3,
    REG_RAW_UP   = 3'd4,
    REG_RAW_LOW  = 3'd5
  } cfg_reg_t;

  // Axis counter runs x, y, z.
  localparam logic [1:0] AXIS_FIRST = 2'd0;
  localparam logic [1:0] AXIS_LAST  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMA_PREP,
    ST_EMA_MUL,
    ST_EMA_ACC,
    ST_SQ_PREP,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_ROOT_START,
    ST_ROOT_WAIT,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/asd_if.sv =====
// ----------------------------------------------------------------------------
// asd_if
// Valid/ready channels of the step detector: sample input, result output and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface asd_sample_if import asd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic        [TIME_W-1:0]       time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface asd_result_if import asd_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [MAG_W-1:0]       dynamic_magnitude;
  logic [OUT_COUNT_W-1:0] raw_step_count;
  logic [OUT_COUNT_W-1:0] filtered_step_count;
  logic                   filtered_step_now;

  modport source (output valid, dynamic_magnitude, raw_step_count, filtered_step_count,
                  filtered_step_now, input ready);
  modport sink   (input valid, dynamic_magnitude, raw_step_count, filtered_step_count,
                  filtered_step_now, output ready);
endinterface

interface asd_cfg_if import asd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/accel_step_detector_top.sv =====
// ----------------------------------------------------------------------------
// accel_step_detector_top
// Step counter on 3-axis acceleration samples with gravity tracking, a raw
// magnitude counter and a time-debounced dynamic magnitude counter.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one word per sample (accel_x/y/z signed Q8.8, time_ms) on a
//            valid/ready channel.
//   result : one word per sample (dynamic magnitude, both step counts and the
//            filtered step flag) from an output register.
//   cfg    : register writes (index, data), always ready and applied at once;
//            write only while no sample is in flight.
// One shared signed multiplier runs the three gravity averages and the six
// squares, and one bit-per-cycle square root unit forms both magnitudes. A
// sample runs through the gravity averages, the raw squares and root, the
// dynamic squares and root and the update step to its result word; the block
// takes the next sample only after that, one sample at a time. A new sample
// may be accepted while the previous result still waits; if the receiver
// stalls, the block holds the finished result of the following sample in its
// last step until the register frees.
// Reset restores the register defaults, clears the counters and latches and
// marks gravity unseeded, so the next sample seeds it.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_step_detector_top import asd_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  asd_sample_if.sink    sample,
  asd_result_if.source  result,
  asd_cfg_if.sink       cfg
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int S16_W  = W + 8;        // sample in Q8.16
  localparam int G_W    = W + 9;        // gravity average
  localparam int MW     = W + 10;       // multiplier operand
  localparam int PW     = 2 * MW;       // multiplier product
  localparam int EW     = W + 27;       // average accumulation
  localparam int DDW    = W + 11;       // difference before rounding
  localparam int DW     = W + 2;        // rounded Q10.8 difference
  localparam int RT_W   = W + 1;        // square root width
  localparam int SQ_W   = 2 * RT_W;     // sum of squares
  localparam int CMP_W  = RT_W + MAG_W;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] alpha;
  logic [CFG_DATA_W-1:0] filt_up;
  logic [CFG_DATA_W-1:0] filt_low;
  logic [CFG_DATA_W-1:0] min_step;
  logic [CFG_DATA_W-1:0] raw_up;
  logic [CFG_DATA_W-1:0] raw_low;

  // Block state.
  logic                   seeded;
  logic                   raw_latch;
  logic                   filt_latch;
  logic [TIME_W-1:0]      last_time;
  logic [COUNT_WIDTH-1:0] raw_cnt;
  logic [COUNT_WIDTH-1:0] filt_cnt;
  logic signed [G_W-1:0]  g [3];

  // Sequencer and datapath.
  logic [1:0]             k;
  logic                   pass;
  logic signed [W-1:0]    samp [3];
  logic [TIME_W-1:0]      t_ms;
  logic signed [MW-1:0]   opa;
  logic signed [MW-1:0]   opb;
  logic signed [PW-1:0]   prod;
  logic [SQ_W-1:0]        acc;
  logic [MAG_W-1:0]       raw_mag;
  logic [MAG_W-1:0]       dyn_mag;

  // Result register.
  logic                   out_valid;
  logic [MAG_W-1:0]       out_dyn;
  logic [OUT_COUNT_W-1:0] out_raw_cnt;
  logic [OUT_COUNT_W-1:0] out_filt_cnt;
  logic                   out_now;

  logic                   in_accept;
  logic                   root_start;
  logic                   root_done;
  logic [RT_W-1:0]        root;
  logic                   upd_go;

  logic signed [S16_W-1:0] s16_k;
  logic signed [MW-1:0]    ema_diff;
  logic signed [EW-1:0]    ema_sum;
  logic signed [DW-1:0]    dyn_d;
  logic signed [MW-1:0]    sq_operand;
  logic [MAG_W-1:0]        root_sat;

  logic                   raw_hit;
  logic                   raw_clear;
  logic                   filt_arm;
  logic                   filt_hit;
  logic                   filt_clear;
  logic [TIME_W-1:0]      elapsed;
  logic [COUNT_WIDTH-1:0] raw_cnt_next;
  logic [COUNT_WIDTH-1:0] filt_cnt_next;

  asd_isqrt #(
    .RT_W (RT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (acc),
    .done     (root_done),
    .root     (root)
  );

  assign cfg.ready                  = 1'b1;
  assign result.valid               = out_valid;
  assign result.dynamic_magnitude   = out_dyn;
  assign result.raw_step_count      = out_raw_cnt;
  assign result.filtered_step_count = out_filt_cnt;
  assign result.filtered_step_now   = out_now;

  // Arithmetic around the shared multiplier.
  always_comb begin
    s16_k    = S16_W'(samp[k]) <<< 8;
    ema_diff = MW'(g[k]) - MW'(s16_k);
    // alpha*g + (1-alpha)*s equals s + alpha*(g - s); the added 32768 rounds the shift.
    ema_sum  = (EW'(s16_k) <<< 16) + EW'(prod) + EW'(32768);
    dyn_d    = DW'((DDW'(s16_k) - DDW'(g[k]) + DDW'(128)) >>> 8);
    sq_operand = pass ? MW'(dyn_d) : MW'(samp[k]);
    root_sat = (CMP_W'(root) > CMP_W'(MAG_MAX)) ? MAG_MAX : MAG_W'(root);
  end

  // Hysteresis for both counters.
  always_comb begin
    raw_hit    = (raw_mag > raw_up) && !raw_latch;
    raw_clear  = !raw_hit && (raw_mag < raw_low);
    elapsed    = t_ms - last_time;
    filt_arm   = (dyn_mag > filt_up) && !filt_latch;
    filt_hit   = filt_arm && (elapsed > TIME_W'(min_step));
    filt_clear = !filt_arm && (dyn_mag < filt_low);
    raw_cnt_next  = raw_hit  ? raw_cnt  + COUNT_WIDTH'(1) : raw_cnt;
    filt_cnt_next = filt_hit ? filt_cnt + COUNT_WIDTH'(1) : filt_cnt;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (sample.valid) state_next = ST_EMA_PREP;
      ST_EMA_PREP:   state_next = ST_EMA_MUL;
      ST_EMA_MUL:    state_next = ST_EMA_ACC;
      ST_EMA_ACC:    state_next = (k == AXIS_LAST) ? ST_SQ_PREP : ST_EMA_PREP;
      ST_SQ_PREP:    state_next = ST_SQ_MUL;
      ST_SQ_MUL:     state_next = ST_SQ_ACC;
      ST_SQ_ACC:     state_next = (k == AXIS_LAST) ? ST_ROOT_START : ST_SQ_PREP;
      ST_ROOT_START: state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (root_done) state_next = pass ? ST_UPDATE : ST_SQ_PREP;
      end
      ST_UPDATE:     if (upd_go) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = (state == ST_IDLE);
    root_start   = (state == ST_ROOT_START);
    upd_go       = (state == ST_UPDATE) && (!out_valid || result.ready);
    in_accept    = sample.valid && sample.ready;
  end

  // Control state, configuration and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      alpha      <= ALPHA_RST;
      filt_up    <= FILT_UP_RST;
      filt_low   <= FILT_LOW_RST;
      min_step   <= MIN_STEP_RST;
      raw_up     <= RAW_UP_RST;
      raw_low    <= RAW_LOW_RST;
      seeded     <= 1'b0;
      raw_latch  <= 1'b0;
      filt_latch <= 1'b0;
      last_time  <= '0;
      raw_cnt    <= '0;
      filt_cnt   <= '0;
      k          <= AXIS_FIRST;
      pass       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          REG_ALPHA:    alpha    <= cfg.data;
          REG_FILT_UP:  filt_up  <= cfg.data;
          REG_FILT_LOW: filt_low <= cfg.data;
          REG_MIN_STEP: min_step <= cfg.data;
          REG_RAW_UP:   raw_up   <= cfg.data;
          REG_RAW_LOW:  raw_low  <= cfg.data;
          default: ;
        endcase
      end

      if (upd_go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            k      <= AXIS_FIRST;
            pass   <= 1'b0;
            seeded <= 1'b1;
          end
        end
        ST_EMA_ACC, ST_SQ_ACC: begin
          k <= (k == AXIS_LAST) ? AXIS_FIRST : k + 2'd1;
        end
        ST_ROOT_WAIT: begin
          if (root_done) pass <= 1'b1;
        end
        ST_UPDATE: begin
          if (upd_go) begin
            raw_cnt   <= raw_cnt_next;
            filt_cnt  <= filt_cnt_next;
            if (raw_hit) begin
              raw_latch <= 1'b1;
            end else if (raw_clear) begin
              raw_latch <= 1'b0;
            end
            if (filt_hit) begin
              filt_latch <= 1'b1;
              last_time  <= t_ms;
            end else if (filt_clear) begin
              filt_latch <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          samp[0] <= sample.accel_x;
          samp[1] <= sample.accel_y;
          samp[2] <= sample.accel_z;
          t_ms    <= sample.time_ms;
          // The first sample after reset seeds gravity before averaging.
          if (!seeded) begin
            g[0] <= G_W'(S16_W'(sample.accel_x) <<< 8);
            g[1] <= G_W'(S16_W'(sample.accel_y) <<< 8);
            g[2] <= G_W'(S16_W'(sample.accel_z) <<< 8);
          end
        end
      end
      ST_EMA_PREP: begin
        opa <= signed'(MW'(alpha));
        opb <= ema_diff;
      end
      ST_EMA_MUL, ST_SQ_MUL: begin
        prod <= opa * opb;
      end
      ST_EMA_ACC: begin
        g[k] <= G_W'(ema_sum >>> 16);
        if (k == AXIS_LAST) acc <= '0;
      end
      ST_SQ_PREP: begin
        opa <= sq_operand;
        opb <= sq_operand;
      end
      ST_SQ_ACC: begin
        acc <= acc + SQ_W'(prod);
      end
      ST_ROOT_WAIT: begin
        if (root_done) begin
          if (pass) begin
            dyn_mag <= root_sat;
          end else begin
            raw_mag <= root_sat;
            acc     <= '0;
          end
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          out_dyn      <= dyn_mag;
          out_raw_cnt  <= OUT_COUNT_W'(raw_cnt_next);
          out_filt_cnt <= OUT_COUNT_W'(filt_cnt_next);
          out_now      <= filt_hit;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/asd_isqrt.sv =====
// ----------------------------------------------------------------------------
// asd_isqrt
// Iterative integer square root, one result bit per cycle (restoring digit
// recurrence on two radicand bits at a time).
// ----------------------------------------------------------------------------
`default_nettype none

module asd_isqrt #(
  parameter int RT_W = 17
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2*RT_W-1:0] radicand,
  output logic                   done,
  output logic      [RT_W-1:0]   root
);

  localparam int RAD_W = 2 * RT_W;
  localparam int REM_W = RT_W + 2;
  localparam int CND_W = REM_W + 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [CND_W-1:0] cand;
  logic [CND_W-1:0] trial;
  logic [CND_W-1:0] diff;
  logic             ge;

  always_comb begin
    cand  = {rem, rad[RAD_W-1 -: 2]};
    trial = CND_W'({root, 2'b01});
    diff  = cand - trial;
    ge    = (cand >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? REM_W'(diff) : REM_W'(cand);
      root <= {root[RT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/asd_checker.sv =====
// ----------------------------------------------------------------------------
// asd_checker
// Port-level assertions of the step detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module asd_checker import asd_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [MAG_W-1:0]       out_dyn,
  input wire logic [OUT_COUNT_W-1:0] out_raw,
  input wire logic [OUT_COUNT_W-1:0] out_filt,
  input wire logic                   out_now
);

  // The block works on one sample at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready held high after a sample was accepted");

  // A result word appears only at the end of a sample's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word appeared while the block was idle");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_dyn) && $stable(out_raw) && $stable(out_filt) &&
       $stable(out_now)))
    else $error("stalled result word changed");

endmodule

bind accel_step_detector_top asd_checker u_asd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_dyn   (result.dynamic_magnitude),
  .out_raw   (result.raw_step_count),
  .out_filt  (result.filtered_step_count),
  .out_now   (result.filtered_step_now)
);

`default_nettype wire
